>>> hw/rtl/sva_pkg.sv
package sva_pkg;

  // Set sizes and arithmetic widths
  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_BITS   = 8;
  localparam int CNT_W       = 13;
  localparam int SUM_W       = 28;
  localparam int SQ_W        = 43;
  localparam int VAR_W       = 40;
  localparam int STAT_W      = 2;

  // n * S2 is split into two partial products at this bit
  localparam int LO_W        = 22;
  localparam int HI_W        = SQ_W - LO_W;
  localparam int PLO_W       = CNT_W + LO_W;
  localparam int PHI_W       = CNT_W + HI_W;
  localparam int NUM_W       = 56;
  localparam int DVD_W       = NUM_W + FRAC_BITS;
  localparam int DEN_W       = 24;
  localparam int DIV_CNT_W   = 6;

  localparam logic [CNT_W-1:0]     CNT_MAX  = CNT_W'(MAX_SAMPLES);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FEW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MANY = 2'd2;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DIFF,
    ST_DIV
  } sva_state_t;

  typedef struct packed {
    logic accept;
    logic last;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic diff;
    logic div_step;
    logic out_load_err;
    logic out_load_div;
  } sva_cmd_t;

  typedef struct packed {
    logic last_err;
    logic div_done;
  } sva_stat_t;

endpackage

>>> hw/rtl/sva_ctrl.sv
module sva_ctrl
  import sva_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  sva_stat_t stat,
  output sva_cmd_t  cmd
);

  sva_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;

  // Hold off requests while a set is being finished, or a last sample with a result pending
  assign in_stall  = (state_r != ST_ACC) || (in_last && out_valid_r);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACC: begin
        if (acc && in_last && !stat.last_err) state_nxt = ST_MUL_A;
      end
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) state_nxt = ST_ACC;
      end
      default:  state_nxt = ST_ACC;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd              = '0;
    cmd.accept       = acc;
    cmd.last         = in_last;
    unique case (state_r)
      ST_ACC:   cmd.out_load_err = acc && in_last && stat.last_err;
      ST_MUL_A: cmd.mul_a = 1'b1;
      ST_MUL_B: cmd.mul_b = 1'b1;
      ST_SUM:   cmd.sum = 1'b1;
      ST_DIFF:  cmd.diff = 1'b1;
      ST_DIV: begin
        cmd.div_step     = 1'b1;
        cmd.out_load_div = stat.div_done;
      end
      default:  cmd.out_load_err = 1'b0;
    endcase
  end

  // Raise valid on a new result, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load_err || cmd.out_load_div) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/sva_dpath.sv
module sva_dpath
  import sva_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  sva_cmd_t                   cmd,
  output sva_stat_t                  stat,
  output logic        [VAR_W-1:0]    out_variance,
  output logic        [STAT_W-1:0]   out_status
);

  // Running accumulators
  logic        [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic        [SQ_W-1:0]   sq_r, sq_nxt;
  logic                     ovf_r, ovf_nxt;

  // Set snapshot and arithmetic pipeline
  logic        [CNT_W-1:0]  n_r;
  logic        [SUM_W-1:0]  sabs_r;
  logic        [SQ_W-1:0]   s2_r;
  logic        [PLO_W-1:0]  plo_r;
  logic        [PHI_W-1:0]  phi_r;
  logic        [NUM_W-1:0]  s1sq_r, ns2_r;
  logic        [DEN_W-1:0]  den_r;
  logic        [2*CNT_W-1:0] den_full;
  logic        [NUM_W-1:0]  num;

  // Restoring divider
  logic        [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic        [DEN_W-1:0]     rem_r, rem_nxt;
  logic        [DEN_W:0]       rem_sh, rem_sub;
  logic        [DIV_CNT_W-1:0] div_cnt_r;
  logic                        ge;

  logic        [SAMPLE_W-1:0]  ax;
  logic        [2*SAMPLE_W-1:0] sq_x;
  logic        [STAT_W-1:0]    live_status;
  logic        [VAR_W-1:0]     out_variance_r;
  logic        [STAT_W-1:0]    out_status_r;

  // Square and add one sample, saturating the count
  assign ax   = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
  assign sq_x = (2*SAMPLE_W)'(ax) * (2*SAMPLE_W)'(ax);

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    ovf_nxt = ovf_r;
    if (cnt_r < CNT_MAX) begin
      cnt_nxt = cnt_r + 1'b1;
      sum_nxt = sum_r + SUM_W'(in_sample);
      sq_nxt  = sq_r + SQ_W'(sq_x);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  // Status of the set if this sample closes it
  always_comb begin
    if (ovf_nxt) begin
      live_status = STAT_MANY;
    end else if (cnt_nxt < CNT_W'(2)) begin
      live_status = STAT_FEW;
    end else begin
      live_status = STAT_OK;
    end
  end

  assign stat.last_err = (live_status != STAT_OK);
  assign stat.div_done = (div_cnt_r == DIV_LAST);

  // Accumulate, or snapshot and clear on the last sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.accept) begin
      if (cmd.last) begin
        cnt_r <= '0;
        sum_r <= '0;
        sq_r  <= '0;
        ovf_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
        sq_r  <= sq_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.last) begin
      n_r    <= cnt_nxt;
      sabs_r <= sum_nxt[SUM_W-1] ? (~sum_nxt + 1'b1) : sum_nxt;
      s2_r   <= sq_nxt;
    end
  end

  // Products: low half of n*S2, S1 squared and n*(n-1), then the high half
  assign den_full = (2*CNT_W)'(n_r) * (2*CNT_W)'(n_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      plo_r  <= PLO_W'(n_r) * PLO_W'(s2_r[LO_W-1:0]);
      s1sq_r <= NUM_W'(sabs_r) * NUM_W'(sabs_r);
      den_r  <= den_full[DEN_W-1:0];
    end
    if (cmd.mul_b) begin
      phi_r <= PHI_W'(n_r) * PHI_W'(s2_r[SQ_W-1:LO_W]);
    end
    if (cmd.sum) begin
      ns2_r <= NUM_W'(plo_r) + (NUM_W'(phi_r) << LO_W);
    end
  end

  // Clamp the numerator at zero
  assign num = (ns2_r >= s1sq_r) ? (ns2_r - s1sq_r) : '0;

  // One quotient bit per step
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign dvd_nxt = {dvd_r[DVD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dvd_r <= {num, FRAC_BITS'(0)};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.diff) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load_err) begin
      out_variance_r <= '0;
      out_status_r   <= live_status;
    end else if (cmd.out_load_div) begin
      out_variance_r <= dvd_nxt[VAR_W-1:0];
      out_status_r   <= STAT_OK;
    end
  end

  assign out_variance = out_variance_r;
  assign out_status   = out_status_r;

endmodule

>>> hw/rtl/sample_variance_accumulator.sv
// Accumulation takes one sample per cycle while a set is open; a last sample waits while
// a result is pending. A set that ends in error (too few or too many samples) gives its
// result in the cycle after the last sample; a valid set gives it after 4 multiply/add
// steps and a 64-step restoring divider, and input is held off during those steps.
// Synchronous active-low reset clears the accumulators, state machine and output valid.
module sample_variance_accumulator
  import sva_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic        [VAR_W-1:0]    out_variance,
  output logic        [STAT_W-1:0]   out_status
);

  sva_cmd_t  cmd;
  sva_stat_t stat;

  sva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sva_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_sample    (in_sample),
    .cmd          (cmd),
    .stat         (stat),
    .out_variance (out_variance),
    .out_status   (out_status)
  );

endmodule
